// ----- rtl/pdec_pkg.sv -----
// shared types, constants and code-table functions for the percent decoder
`default_nettype none
package pdec_pkg;

   localparam logic [7:0] PCT_CHAR   = 8'h25;
   localparam int         MAX_RES    = 3;
   localparam int         RES_CNT_W  = $clog2(MAX_RES + 1);

   // what the decoder is holding between input transfers
   typedef enum logic [1:0] {
      PH_FREE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } pdec_phase_type;

   // results of one input item, entry 0 goes out first
   typedef struct packed {
      logic [RES_CNT_W-1:0]        count;
      logic [MAX_RES-1:0][7:0]     bytes;
      logic [MAX_RES-1:0]          lasts;
   } pdec_res_type;

   // uppercase hex digit value, bit 4 set when not a digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

   // reserved and commonly escaped characters that may be decoded
   function automatic logic code_listed(input logic [7:0] v);
      logic hit;
      unique case (v)
         8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
         8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
         8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
         8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F, 8'h60,
         8'h7B, 8'h7C, 8'h7D, 8'h7E: hit = 1'b1;
         default:                   hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pdec_if.sv -----
// stream interfaces for escaped input characters and decoded output characters
`default_nettype none
interface pdec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pdec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/pdec_decode.sv -----
// escape scanner: one input character against the held state, up to three results
`default_nettype none
module pdec_decode
   import pdec_pkg::*;
(
   input  wire pdec_phase_type phase,
   input  wire logic [7:0]     held,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output pdec_phase_type      phase_next,
   output logic [7:0]          held_next,
   output pdec_res_type        res
);

   logic [4:0] hi_val;
   logic [4:0] lo_val;
   logic [7:0] pair_val;
   logic       pair_hit;

   assign hi_val   = hex_val(held);
   assign lo_val   = hex_val(in_byte);
   assign pair_val = {hi_val[3:0], lo_val[3:0]};
   assign pair_hit = !hi_val[4] && !lo_val[4] && code_listed(pair_val);

   always_comb begin
      phase_next = PH_FREE;
      held_next  = held;
      res.count  = '0;
      res.bytes  = '0;
      res.lasts  = '0;
      unique case (phase)
         PH_PCT: begin
            if (in_last) begin
               res.count    = RES_CNT_W'(2);
               res.bytes[0] = PCT_CHAR;
               res.bytes[1] = in_byte;
               res.lasts[1] = 1'b1;
            end else begin
               held_next  = in_byte;
               phase_next = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            res.bytes[0] = PCT_CHAR;
            if (pair_hit) begin
               res.count    = RES_CNT_W'(1);
               res.bytes[0] = pair_val;
               res.lasts[0] = in_last;
            end else if (held == PCT_CHAR) begin
               // held '%' restarts the escape
               if (in_last) begin
                  res.count    = RES_CNT_W'(3);
                  res.bytes[1] = PCT_CHAR;
                  res.bytes[2] = in_byte;
                  res.lasts[2] = 1'b1;
               end else begin
                  res.count  = RES_CNT_W'(1);
                  held_next  = in_byte;
                  phase_next = PH_DIGIT;
               end
            end else begin
               res.bytes[1] = held;
               if (in_byte == PCT_CHAR && !in_last) begin
                  res.count  = RES_CNT_W'(2);
                  phase_next = PH_PCT;
               end else begin
                  res.count    = RES_CNT_W'(3);
                  res.bytes[2] = in_byte;
                  res.lasts[2] = in_last;
               end
            end
         end
         default: begin
            if (in_byte == PCT_CHAR && !in_last) begin
               phase_next = PH_PCT;
            end else begin
               res.count    = RES_CNT_W'(1);
               res.bytes[0] = in_byte;
               res.lasts[0] = in_last;
            end
         end
      endcase
      if (phase_next == PH_FREE) begin
         held_next = '0;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/pdec_outbuf.sv -----
// result register: holds the results of one item and drains one per transfer
`default_nettype none
module pdec_outbuf
   import pdec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire pdec_res_type res,
   output logic              room,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [7:0]        out_byte,
   output logic              out_last
);

   logic [RES_CNT_W-1:0]    cnt_ff,   cnt_in;
   logic [MAX_RES-1:0][7:0] bytes_ff, bytes_in;
   logic [MAX_RES-1:0]      lasts_ff, lasts_in;
   logic                    pop;

   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign room      = (cnt_ff == '0) || (cnt_ff == RES_CNT_W'(1) && out_ready);
   assign out_byte  = bytes_ff[0];
   assign out_last  = lasts_ff[0];

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      lasts_in = lasts_ff;
      if (pop) begin
         cnt_in = cnt_ff - RES_CNT_W'(1);
         for (int i = 0; i < MAX_RES - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
            lasts_in[i] = lasts_ff[i+1];
         end
      end
      if (load) begin
         cnt_in   = res.count;
         bytes_in = res.bytes;
         lasts_in = res.lasts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      lasts_ff <= lasts_in;
   end

endmodule
`default_nettype wire

// ----- rtl/percent_decoder_stream.sv -----
// top level of the streaming url percent decoder
//
//  channel  dir  payload             handshake
//  req_ch   in   in_byte, in_last    valid/ready, transfer when both high
//  rsp_ch   out  out_byte, out_last  valid/ready, transfer when both high
//
// - one input per cycle if the output is ready and items give at most one result
// - an item gives up to three results, drained one per cycle from the result
//   register while rsp_ch.ready is high; input waits till the last is leaving
// - an item's first result is presented the cycle after its input transfer
// - synchronous active-high reset clears phase, held character and count
// - output stalls back up to req_ch.ready combinationally through the room check
`default_nettype none
module percent_decoder_stream
   import pdec_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   pdec_req_if.sink   req_ch,
   pdec_rsp_if.source rsp_ch
);

   // scanner state
   pdec_phase_type phase_ff, phase_in;
   logic [7:0]     held_ff,  held_in;

   pdec_res_type   dec_res;
   logic           room;
   logic           req_take;

   assign req_ch.ready = room;
   assign req_take     = req_ch.valid && room;

   pdec_decode u_decode (
      .phase      (phase_ff),
      .held       (held_ff),
      .in_byte    (req_ch.in_byte),
      .in_last    (req_ch.in_last),
      .phase_next (phase_in),
      .held_next  (held_in),
      .res        (dec_res)
   );

   // state advances only on an input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FREE;
         held_ff  <= '0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   pdec_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .res       (dec_res),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_byte  (rsp_ch.out_byte),
      .out_last  (rsp_ch.out_last)
   );

   // held character is cleared whenever nothing is held
   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FREE) |-> (held_ff == '0))
      else $error("held character set while nothing is held");

   // the final input character always ends the string on the output
   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.in_last) |->
         (dec_res.count != '0 && dec_res.lasts[dec_res.count - RES_CNT_W'(1)]))
      else $error("end of string not marked on final result");

   // the end of string leaves nothing held
   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.in_last) |=> (phase_ff == PH_FREE))
      else $error("state held across end of string");

   // a fresh escape start yields no result
   a_pct_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == PH_FREE && req_ch.in_byte == PCT_CHAR && !req_ch.in_last)
         |-> (dec_res.count == '0))
      else $error("percent start produced output");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

// ----- bench/pdec_checker.sv -----
`timescale 1ns / 100ps
// checker for the percent decoder: predicts each decoded character and compares the output channel
module pdec_checker
   import pdec_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pdec_req_if       req_mon,
   pdec_rsp_if       rsp_mon,
   output int        error_count,
   output int        pending_results
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   // reserved and commonly escaped characters that an escape may produce
   localparam logic [7:0] ESCAPABLE [0:32] = '{
      8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2F,
      8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D,
      8'h20, 8'h22, 8'h25, 8'h2D, 8'h2E, 8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h5F, 8'h60,
      8'h7B, 8'h7C, 8'h7D, 8'h7E
   };

   out_char_type   decoded_chars [$];
   pdec_phase_type scan_phase;
   logic [7:0]     held_char;

   // value of an uppercase hex digit, -1 otherwise
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic bit escape_hit(input logic [7:0] hi_c, input logic [7:0] lo_c,
                                     output logic [7:0] value);
      int hi;
      int lo;
      hi = nibble_of(hi_c);
      lo = nibble_of(lo_c);
      value = 8'h00;
      if (hi < 0 || lo < 0) return 1'b0;
      value = 8'(hi * 16 + lo);
      foreach (ESCAPABLE[i]) begin
         if (ESCAPABLE[i] == value) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic emit_char(input logic [7:0] c, input logic l);
      out_char_type item;
      item.ch       = c;
      item.last     = l;
      decoded_chars = {decoded_chars, item};
   endtask

   task automatic scan_plain(input logic [7:0] b, input logic l);
      if (b == PCT_CHAR && !l) begin
         scan_phase = PH_PCT;
      end else begin
         emit_char(b, l);
         scan_phase = PH_FREE;
      end
   endtask

   task automatic decode_char(input logic [7:0] b, input logic l);
      logic [7:0] value;
      case (scan_phase)
         PH_PCT: begin
            if (l) begin
               emit_char(PCT_CHAR, 1'b0);
               emit_char(b, 1'b1);
               scan_phase = PH_FREE;
            end else begin
               held_char  = b;
               scan_phase = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            if (escape_hit(held_char, b, value)) begin
               emit_char(value, l);
               scan_phase = PH_FREE;
            end else begin
               emit_char(PCT_CHAR, 1'b0);
               if (held_char == PCT_CHAR) begin
                  // held percent opens a new escape
                  if (l) begin
                     emit_char(PCT_CHAR, 1'b0);
                     emit_char(b, 1'b1);
                     scan_phase = PH_FREE;
                  end else begin
                     held_char = b;
                  end
               end else begin
                  emit_char(held_char, 1'b0);
                  scan_plain(b, l);
               end
            end
         end
         default: scan_plain(b, l);
      endcase
      if (scan_phase == PH_FREE) held_char = 8'h00;
   endtask

   always @(posedge clock) begin
      out_char_type want;
      if (reset) begin
         scan_phase = PH_FREE;
         held_char  = 8'h00;
         decoded_chars.delete();
      end else begin
         // results at this edge belong to earlier transfers
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (decoded_chars.size() == 0) begin
               $error("result %h last %b with nothing expected",
                      rsp_mon.out_byte, rsp_mon.out_last);
               error_count++;
            end else begin
               want = decoded_chars.pop_front();
               if (rsp_mon.out_byte !== want.ch) begin
                  $error("out_byte: expected %h, actual %h", want.ch, rsp_mon.out_byte);
                  error_count++;
               end
               if (rsp_mon.out_last !== want.last) begin
                  $error("out_last: expected %b, actual %b", want.last, rsp_mon.out_last);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) decode_char(req_mon.in_byte, req_mon.in_last);
      end
      pending_results = decoded_chars.size();
   end

endmodule

// ----- bench/tb_percent_decoder_stream.sv -----
`timescale 1ns / 100ps
// top of the percent decoder bench: clock, reset, stimulus, back-pressure and verdict
module tb_percent_decoder_stream;
   import pdec_pkg::*;

   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
   localparam int RANDOM_ITEMS = 420;
   localparam int CALM_ITEMS   = 60;    // closing stretch with no idling
   localparam int N_DIRECTED   = 27;

   // directed strings, one character per entry
   localparam logic [7:0] DIRECTED_BYTES [0:N_DIRECTED-1] = '{
      8'h00, 8'hFF,                  // byte extremes, two-char string
      8'h25, 8'h32, 8'h31,           // listed escape decodes to '!'
      8'h25, 8'h32, 8'h61,           // lowercase hex passes literally
      8'h25, 8'h32, 8'h35,           // escape gives a percent, not rescanned
      8'h25, 8'h25, 8'h32, 8'h31,    // second percent starts a new escape, ends string
      8'h25, 8'h5A,                  // end of string with only the percent held
      8'h25, 8'h32, 8'h25,           // end of string with percent and digit held
      8'h25, 8'h37, 8'h46,           // hex pair that is not listed
      8'h25,                         // lone percent as final character
      8'h25, 8'h25, 8'h41            // end of string with two percents held
   };
   localparam bit DIRECTED_LASTS [0:N_DIRECTED-1] = '{
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0,
      1'b1,
      1'b0, 1'b0, 1'b1
   };

   logic clock;
   logic reset;
   int   error_count;
   int   pending_results;
   int   quiet_cycles   = 0;
   int   send_gap_pct   = 0;   // chance of an idle burst before a character
   int   recv_stall_pct = 0;   // chance of a ready-low burst on the output

   pdec_req_if req_ch ();
   pdec_rsp_if rsp_ch ();

   percent_decoder_stream dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pdec_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // output back-pressure: ready drops low in random bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < recv_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ascii hex digit, lowercase letters on request
   function automatic logic [7:0] digit_char(input int n, input bit lower);
      if (n < 10) return 8'(8'h30 + n);
      return 8'((lower ? 8'h61 : 8'h41) + n - 10);
   endfunction

   function automatic int idle_choice();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   // one character transfer, with an optional idle burst before it;
   // returns at the rising edge of the transfer
   task automatic send_char(input logic [7:0] b, input logic l);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= l;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // random string built from escapes, literals and broken escapes
   task automatic send_random_string(inout int sent);
      logic [7:0] text [$];
      int         segs;
      int         pick;
      int         hi;
      segs = $urandom_range(1, 5);
      repeat (segs) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // mostly rows that hold listed codes, sometimes any digit
            hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 7);
            text = {text, PCT_CHAR};
            text = {text, digit_char(hi, $urandom_range(0, 9) == 0)};
            text = {text, digit_char($urandom_range(0, 15), $urandom_range(0, 9) == 0)};
         end else if (pick < 60) begin
            text = {text, 8'($urandom_range(0, 255))};
         end else if (pick < 75) begin
            text = {text, 8'($urandom_range(8'h21, 8'h7E))};
         end else if (pick < 85) begin
            text = {text, PCT_CHAR};
            text = {text, 8'($urandom_range(0, 255))};
         end else if (pick < 92) begin
            text = {text, PCT_CHAR};
            text = {text, PCT_CHAR};
         end else begin
            text = {text, PCT_CHAR};
            text = {text, 8'($urandom_range(0, 255))};
            text = {text, 8'($urandom_range(0, 255))};
         end
      end
      foreach (text[k]) send_char(text[k], k == text.size() - 1);
      sent += text.size();
   endtask

   initial begin
      int sent;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.in_last = 1'b0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed strings under light idling on both sides
      send_gap_pct   = 20;
      recv_stall_pct = 20;
      for (int i = 0; i < N_DIRECTED; i++) send_char(DIRECTED_BYTES[i], DIRECTED_LASTS[i]);

      // random strings, idling mode changes now and then, calm at the end
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            send_gap_pct   = idle_choice();
            recv_stall_pct = idle_choice();
         end
         send_random_string(sent);
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      // drain, then idle before the verdict
      while (pending_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (error_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
